### hdl/mrhof_pkg.sv
// Shared types and constants for the MRHOF parent selection block.
`timescale 1ns / 1ps
`default_nettype none

package mrhof_pkg;

   localparam logic [15:0] COST_MAX = 16'hFFFF;

   localparam logic [15:0] RST_MAX_LINK_METRIC = 16'd512;
   localparam logic [15:0] RST_MAX_PATH_COST   = 16'd32768;
   localparam logic [15:0] RST_RANK_THRESHOLD  = 16'd192;
   localparam logic [31:0] RST_TIME_THRESHOLD  = 32'd76800;
   localparam logic [15:0] RST_MIN_HOP_RANK    = 16'd256;

   typedef enum logic [1:0] {
      CHOICE_NONE = 2'd0,
      CHOICE_A    = 2'd1,
      CHOICE_B    = 2'd2
   } choice_type;

   typedef enum logic [2:0] {
      CSR_SQUARED_MODE    = 3'd0,
      CSR_MAX_LINK_METRIC = 3'd1,
      CSR_MAX_PATH_COST   = 3'd2,
      CSR_RANK_THRESHOLD  = 3'd3,
      CSR_TIME_THRESHOLD  = 3'd4,
      CSR_MIN_HOP_RANK    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic        present;
      logic [15:0] rank;
      logic [15:0] etx;
      logic        better_set;
      logic [31:0] better_elapsed;
   } nbr_type;

   typedef struct packed {
      nbr_type     a;
      nbr_type     b;
      logic [1:0]  pref;
   } pair_type;

endpackage

`default_nettype wire

### hdl/mrhof_parent_select.sv
// Top level of the MRHOF parent selection pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Compares two candidate neighbors per transaction and returns the preferred parent, its
// path cost, the rank through it and whether each neighbor is acceptable. The block
// accepts one transaction per clock cycle provided rsp_ready stays high. The pipeline
// has six register stages on the squared-ETX path, one for each step: the square,
// a multiply by the reciprocal of ETX_DIVISOR, a multiply-back for the quotient
// correction, the path cost sum, the limit and hysteresis compares, and the final
// selection. Configuration writes take effect at once and must only be issued while
// no transaction is in flight.
module mrhof_parent_select #(
   parameter int ETX_DIVISOR = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [31:0] csr_wdata,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_a_present,
   input  wire logic [15:0] req_a_rank,
   input  wire logic [15:0] req_a_etx,
   input  wire logic        req_a_better_set,
   input  wire logic [31:0] req_a_better_elapsed,
   input  wire logic        req_b_present,
   input  wire logic [15:0] req_b_rank,
   input  wire logic [15:0] req_b_etx,
   input  wire logic        req_b_better_set,
   input  wire logic [31:0] req_b_better_elapsed,
   input  wire logic [1:0]  req_preferred_which,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_choice,
   output logic [15:0]      rsp_chosen_path_cost,
   output logic [15:0]      rsp_rank_via_chosen,
   output logic             rsp_a_acceptable,
   output logic             rsp_b_acceptable
);
   import mrhof_pkg::*;

   localparam logic [15:0] DIV       = 16'(ETX_DIVISOR);
   localparam logic [32:0] RECIP     = 33'((64'd1 << 32) / ETX_DIVISOR);
   localparam logic [32:0] SAT_LIMIT = 33'(64'(ETX_DIVISOR) << 16);

   // Configuration registers.
   logic        squared_mode_ff;
   logic [15:0] max_link_metric_ff;
   logic [15:0] max_path_cost_ff;
   logic [15:0] rank_threshold_ff;
   logic [31:0] time_threshold_ff;
   logic [15:0] min_hop_rank_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         squared_mode_ff    <= 1'b0;
         max_link_metric_ff <= RST_MAX_LINK_METRIC;
         max_path_cost_ff   <= RST_MAX_PATH_COST;
         rank_threshold_ff  <= RST_RANK_THRESHOLD;
         time_threshold_ff  <= RST_TIME_THRESHOLD;
         min_hop_rank_ff    <= RST_MIN_HOP_RANK;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_SQUARED_MODE:    squared_mode_ff    <= csr_wdata[0];
            CSR_MAX_LINK_METRIC: max_link_metric_ff <= csr_wdata[15:0];
            CSR_MAX_PATH_COST:   max_path_cost_ff   <= csr_wdata[15:0];
            CSR_RANK_THRESHOLD:  rank_threshold_ff  <= csr_wdata[15:0];
            CSR_TIME_THRESHOLD:  time_threshold_ff  <= csr_wdata;
            CSR_MIN_HOP_RANK:    min_hop_rank_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Stage enables and valid bits.
   logic [6:1] v_ff;
   logic [6:1] en;

   always_comb begin
      en[6] = !v_ff[6] || rsp_ready;
      for (int k = 5; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[1]) begin
            v_ff[1] <= req_valid;
         end
         for (int k = 2; k <= 6; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   pair_type req_pair;
   always_comb begin
      req_pair.a.present        = req_a_present;
      req_pair.a.rank           = req_a_rank;
      req_pair.a.etx            = req_a_etx;
      req_pair.a.better_set     = req_a_better_set;
      req_pair.a.better_elapsed = req_a_better_elapsed;
      req_pair.b.present        = req_b_present;
      req_pair.b.rank           = req_b_rank;
      req_pair.b.etx            = req_b_etx;
      req_pair.b.better_set     = req_b_better_set;
      req_pair.b.better_elapsed = req_b_better_elapsed;
      req_pair.pref             = req_preferred_which;
   end

   // Stage 1: square of the ETX.
   pair_type         s1_pair_ff;
   logic [1:0][31:0] s1_sq_ff;
   logic [1:0][31:0] s1_sq_in;

   always_comb begin
      s1_sq_in[0] = req_a_etx * req_a_etx;
      s1_sq_in[1] = req_b_etx * req_b_etx;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_pair_ff <= req_pair;
         s1_sq_ff   <= s1_sq_in;
      end
   end

   // Stage 2: estimated quotient by reciprocal, and saturation check.
   pair_type         s2_pair_ff;
   logic [1:0][31:0] s2_sq_ff;
   logic [1:0][15:0] s2_q0_ff;
   logic [1:0][15:0] s2_q0_in;
   logic [1:0]       s2_sat_ff;
   logic [1:0]       s2_sat_in;
   logic [1:0][63:0] s2_prod;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         s2_prod[i]   = s1_sq_ff[i] * RECIP[31:0];
         s2_q0_in[i]  = (ETX_DIVISOR == 1) ? s1_sq_ff[i][15:0] : s2_prod[i][47:32];
         s2_sat_in[i] = {1'b0, s1_sq_ff[i]} >= SAT_LIMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_pair_ff <= s1_pair_ff;
         s2_sq_ff   <= s1_sq_ff;
         s2_q0_ff   <= s2_q0_in;
         s2_sat_ff  <= s2_sat_in;
      end
   end

   // Stage 3: multiply the estimate back for the remainder.
   pair_type         s3_pair_ff;
   logic [1:0][31:0] s3_sq_ff;
   logic [1:0][15:0] s3_q0_ff;
   logic [1:0]       s3_sat_ff;
   logic [1:0][31:0] s3_back_ff;
   logic [1:0][31:0] s3_back_in;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         s3_back_in[i] = s2_q0_ff[i] * DIV;
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_pair_ff <= s2_pair_ff;
         s3_sq_ff   <= s2_sq_ff;
         s3_q0_ff   <= s2_q0_ff;
         s3_sat_ff  <= s2_sat_ff;
         s3_back_ff <= s3_back_in;
      end
   end

   // Stage 4: corrected quotient, added metric and path cost.
   pair_type         s4_pair_ff;
   logic [1:0][15:0] s4_cost_ff;
   logic [1:0][15:0] s4_cost_in;
   logic [1:0][31:0] s4_rem;
   logic [1:0][15:0] s4_quot;
   logic [1:0][15:0] s4_added;
   logic [1:0][15:0] s4_rank;
   logic [1:0][15:0] s4_etx;
   logic [1:0][16:0] s4_sum;

   always_comb begin
      s4_rank[0] = s3_pair_ff.a.rank;
      s4_rank[1] = s3_pair_ff.b.rank;
      s4_etx[0]  = s3_pair_ff.a.etx;
      s4_etx[1]  = s3_pair_ff.b.etx;
      for (int i = 0; i < 2; i++) begin
         s4_rem[i]  = s3_sq_ff[i] - s3_back_ff[i];
         s4_quot[i] = s3_q0_ff[i] + 16'(s4_rem[i] >= 32'(DIV));
         if (!squared_mode_ff) begin
            s4_added[i] = s4_etx[i];
         end else if (s3_sat_ff[i]) begin
            s4_added[i] = COST_MAX;
         end else begin
            s4_added[i] = s4_quot[i];
         end
         s4_sum[i]     = {1'b0, s4_rank[i]} + {1'b0, s4_added[i]};
         s4_cost_in[i] = s4_sum[i][16] ? COST_MAX : s4_sum[i][15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_pair_ff <= s3_pair_ff;
         s4_cost_ff <= s4_cost_in;
      end
   end

   // Stage 5: limit checks, hysteresis and cost order.
   pair_type         s5_pair_ff;
   logic [1:0][15:0] s5_cost_ff;
   logic [1:0]       s5_ok_ff;
   logic [1:0]       s5_ok_in;
   logic [1:0]       s5_hyst_ff;
   logic [1:0]       s5_hyst_in;
   logic             s5_a_lt_b_ff;
   logic [1:0]       s5_pres;
   logic [1:0][15:0] s5_etx;
   logic [1:0]       s5_bset;
   logic [1:0][31:0] s5_elapsed;
   logic [1:0][16:0] s5_cost_thr;

   always_comb begin
      s5_pres[0]    = s4_pair_ff.a.present;
      s5_pres[1]    = s4_pair_ff.b.present;
      s5_etx[0]     = s4_pair_ff.a.etx;
      s5_etx[1]     = s4_pair_ff.b.etx;
      s5_bset[0]    = s4_pair_ff.a.better_set;
      s5_bset[1]    = s4_pair_ff.b.better_set;
      s5_elapsed[0] = s4_pair_ff.a.better_elapsed;
      s5_elapsed[1] = s4_pair_ff.b.better_elapsed;
      for (int i = 0; i < 2; i++) begin
         s5_ok_in[i] = s5_pres[i] && (s5_etx[i] <= max_link_metric_ff)
                       && (s4_cost_ff[i] <= max_path_cost_ff);
         s5_cost_thr[i] = {1'b0, s4_cost_ff[i]} + {1'b0, rank_threshold_ff};
         s5_hyst_in[i] = (s5_cost_thr[i] > {1'b0, s4_cost_ff[1-i]})
                         && (!s5_bset[i] || (s5_elapsed[i] <= time_threshold_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s5_pair_ff   <= s4_pair_ff;
         s5_cost_ff   <= s4_cost_ff;
         s5_ok_ff     <= s5_ok_in;
         s5_hyst_ff   <= s5_hyst_in;
         s5_a_lt_b_ff <= s4_cost_ff[0] < s4_cost_ff[1];
      end
   end

   // Stage 6: selection and rank through the chosen neighbor.
   choice_type  choice_in;
   choice_type  choice_ff;
   logic [15:0] cost_in;
   logic [15:0] cost_ff;
   logic [15:0] rank_in;
   logic [15:0] rank_ff;
   logic [1:0]  ok_ff;
   logic [15:0] sel_rank;
   logic [16:0] lb_sum;
   logic [15:0] lb;

   always_comb begin
      if (!s5_ok_ff[0]) begin
         choice_in = s5_ok_ff[1] ? CHOICE_B : CHOICE_NONE;
      end else if (!s5_ok_ff[1]) begin
         choice_in = CHOICE_A;
      end else if ((s5_pair_ff.pref == CHOICE_A) && s5_hyst_ff[1]) begin
         choice_in = CHOICE_A;
      end else if ((s5_pair_ff.pref == CHOICE_B) && s5_hyst_ff[0]) begin
         choice_in = CHOICE_B;
      end else begin
         choice_in = s5_a_lt_b_ff ? CHOICE_A : CHOICE_B;
      end

      sel_rank = (choice_in == CHOICE_A) ? s5_pair_ff.a.rank : s5_pair_ff.b.rank;
      lb_sum   = {1'b0, sel_rank} + {1'b0, min_hop_rank_ff};
      lb       = lb_sum[16] ? COST_MAX : lb_sum[15:0];

      if (choice_in == CHOICE_NONE) begin
         cost_in = COST_MAX;
         rank_in = COST_MAX;
      end else begin
         cost_in = (choice_in == CHOICE_A) ? s5_cost_ff[0] : s5_cost_ff[1];
         rank_in = (lb > cost_in) ? lb : cost_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         choice_ff <= choice_in;
         cost_ff   <= cost_in;
         rank_ff   <= rank_in;
         ok_ff     <= s5_ok_ff;
      end
   end

   assign rsp_valid            = v_ff[6];
   assign rsp_choice           = choice_ff;
   assign rsp_chosen_path_cost = cost_ff;
   assign rsp_rank_via_chosen  = rank_ff;
   assign rsp_a_acceptable     = ok_ff[0];
   assign rsp_b_acceptable     = ok_ff[1];

`ifndef NO_ASSERTIONS
   a_none_is_infinite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_choice == CHOICE_NONE))
      |-> (rsp_chosen_path_cost == COST_MAX) && (rsp_rank_via_chosen == COST_MAX))
      else $error("No parent chosen but cost or rank is finite.");

   a_rank_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_choice != CHOICE_NONE))
      |-> (rsp_rank_via_chosen >= rsp_chosen_path_cost))
      else $error("Rank via chosen parent is below its path cost.");

   a_choice_acceptable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_choice != CHOICE_A) || rsp_a_acceptable)
                    && ((rsp_choice != CHOICE_B) || rsp_b_acceptable))
      else $error("Chosen parent is not acceptable.");

   a_choice_when_any: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_a_acceptable || rsp_b_acceptable))
      |-> (rsp_choice != CHOICE_NONE))
      else $error("An acceptable neighbor exists but none was chosen.");

   a_stall_keeps_stage: assert property (@(posedge clock) disable iff (reset)
      (v_ff[5] && !en[6]) |=> v_ff[5] && v_ff[6])
      else $error("A stalled transaction left the pipeline.");
`endif

endmodule

`default_nettype wire
